>>> sv/mrsp_pkg.sv
// mrsp_pkg: shared types, parse-mode codes and byte constants for the
// MIDI running-status parser. No dependencies.
`default_nettype none

package mrsp_pkg;

    // parse mode codes
    localparam logic [2:0] MODE_RESET  = 3'd0;
    localparam logic [2:0] MODE_SYSEX  = 3'd1;
    localparam logic [2:0] MODE_SINGLE = 3'd2;
    localparam logic [2:0] MODE_FIRST  = 3'd3;
    localparam logic [2:0] MODE_SECOND = 3'd4;

    localparam logic [4:0] ALL_CHANNELS = 5'd16;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [3:0] CMD_SYSTEM  = 4'hF;
    localparam logic [3:0] CMD_PROGRAM = 4'hC;
    localparam logic [3:0] CMD_PRESSURE = 4'hD;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       overrun;
    } rx_beat_t;

    typedef struct packed {
        logic [7:0] msg_status;
        logic [6:0] data_first;
        logic [6:0] data_second;
    } msg_beat_t;

    function automatic logic is_realtime(input logic [7:0] b);
        return (b == 8'hF8) || (b == 8'hFA) || (b == 8'hFB) ||
               (b == 8'hFC) || (b == 8'hFE) || (b == 8'hFF);
    endfunction

endpackage

`default_nettype wire

>>> sv/mrsp_decode.sv
// mrsp_decode: parse state (mode, running status, held first byte) and the
// single-pass decode of one registered byte. Depends on mrsp_pkg.
`default_nettype none

module mrsp_decode (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire mrsp_pkg::rx_beat_t  beat,
    input  wire logic [4:0]          own_channel,
    output logic                     emit,
    output mrsp_pkg::msg_beat_t      msg
);
    import mrsp_pkg::*;

    logic [2:0] mode_reg, mode_next;
    logic [7:0] status_reg, status_next;
    logic [6:0] held_reg, held_next;
    logic       chan_ok;
    logic       mode_data;

    assign chan_ok = (own_channel == ALL_CHANNELS) ||
                     (status_reg[3:0] == own_channel[3:0]);
    assign mode_data = (mode_reg == MODE_SINGLE) || (mode_reg == MODE_FIRST) ||
                       (mode_reg == MODE_SECOND);

    always_comb
    begin
        mode_next   = mode_reg;
        status_next = status_reg;
        held_next   = held_reg;
        emit        = 1'b0;
        msg         = '0;
        if (fire)
        begin
            if (beat.overrun)
            begin
                mode_next = MODE_RESET;
            end
            else if (is_realtime(beat.rx_byte))
            begin
                mode_next = mode_reg;
            end
            else if (beat.rx_byte[7])
            begin
                status_next = beat.rx_byte;
                if (beat.rx_byte == SYSEX_START)
                    mode_next = MODE_SYSEX;
                else if (beat.rx_byte[7:4] == CMD_SYSTEM)
                    mode_next = MODE_RESET;
                else if (beat.rx_byte[7:4] == CMD_PROGRAM ||
                         beat.rx_byte[7:4] == CMD_PRESSURE)
                    mode_next = MODE_SINGLE;
                else
                    mode_next = MODE_FIRST;
            end
            else if (mode_data && status_reg[7:4] != CMD_SYSTEM && chan_ok)
            begin
                case (mode_reg)
                    MODE_FIRST:
                    begin
                        held_next = beat.rx_byte[6:0];
                        mode_next = MODE_SECOND;
                    end
                    MODE_SECOND:
                    begin
                        mode_next      = MODE_FIRST;
                        emit           = 1'b1;
                        msg.data_first = held_reg;
                        // note-on, velocity 0 -> note-off
                        if (status_reg[7:4] == CMD_NOTE_ON && beat.rx_byte[6:0] == 7'd0)
                        begin
                            msg.msg_status  = {CMD_NOTE_OFF, status_reg[3:0]};
                            msg.data_second = 7'd0;
                        end
                        else
                        begin
                            msg.msg_status  = status_reg;
                            msg.data_second = beat.rx_byte[6:0];
                        end
                    end
                    default:
                    begin
                        emit            = 1'b1;
                        msg.msg_status  = status_reg;
                        msg.data_first  = beat.rx_byte[6:0];
                        msg.data_second = 7'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            status_reg <= 8'd0;
            held_reg   <= 7'd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            status_reg <= status_next;
            held_reg   <= held_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/mrsp_out_reg.sv
// mrsp_out_reg: result register with valid/stall toward the sink.
// Depends on mrsp_pkg.
`default_nettype none

module mrsp_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire mrsp_pkg::msg_beat_t msg_in,
    input  wire logic                stall,
    output logic                     free,
    output logic                     valid,
    output mrsp_pkg::msg_beat_t      msg_out
);
    import mrsp_pkg::*;

    logic      valid_reg;
    msg_beat_t msg_reg;

    assign free    = !valid_reg || !stall;
    assign valid   = valid_reg;
    assign msg_out = msg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            msg_reg <= msg_in;
    end

endmodule

`default_nettype wire

>>> sv/midi_running_status_parser_core.sv
// midi_running_status_parser_core: top level of the MIDI running-status parser.
// Holds the input register and own_channel; uses mrsp_decode, mrsp_out_reg, mrsp_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  rx      | in        | rx_valid/rx_stall  | rx_byte[7:0], overrun
//  msg     | out       | msg_valid/msg_stall| msg_status[7:0], data_first[6:0],
//          |           |                    | data_second[6:0]
//  cfg     | in        | cfg_valid/cfg_ready| cfg_data[4:0] (own_channel)
//
// One byte per cycle sustained while msg_stall is low. A byte is captured in the
// input register, decoded in a single pass and, if it completes a message, lands
// in the result register, which drives msg_valid. Reset clears the parse to reset
// mode, running status and held byte to zero, own_channel to 16 (all channels).
// A stalled sink holds the result register; the input register then holds and
// rx_stall rises only while it is full.
`default_nettype none

module midi_running_status_parser_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte input
    input  wire logic       rx_valid,
    output logic            rx_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       overrun,
    // message output
    output logic            msg_valid,
    input  wire logic       msg_stall,
    output logic [7:0]      msg_status,
    output logic [6:0]      data_first,
    output logic [6:0]      data_second,
    // config write
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [4:0] cfg_data
);
    import mrsp_pkg::*;

    logic [4:0] own_channel_reg;
    logic       in_valid_reg;
    rx_beat_t   in_beat_reg;
    logic       out_free;
    logic       fire;
    logic       emit;
    msg_beat_t  dec_msg;
    msg_beat_t  out_msg;

    // config always taken; the user must write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_channel_reg <= ALL_CHANNELS;
        else if (cfg_valid)
            own_channel_reg <= cfg_data;
    end

    // input register advances whenever the result register can take a beat
    assign fire     = in_valid_reg && out_free;
    assign rx_stall = in_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!rx_stall)
            in_valid_reg <= rx_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
            in_beat_reg <= '{rx_byte: rx_byte, overrun: overrun};
    end

    mrsp_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .beat        (in_beat_reg),
        .own_channel (own_channel_reg),
        .emit        (emit),
        .msg         (dec_msg)
    );

    mrsp_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (fire && emit),
        .msg_in  (dec_msg),
        .stall   (msg_stall),
        .free    (out_free),
        .valid   (msg_valid),
        .msg_out (out_msg)
    );

    assign msg_status  = out_msg.msg_status;
    assign data_first  = out_msg.data_first;
    assign data_second = out_msg.data_second;

endmodule

`default_nettype wire

>>> sv/mrsp_checker.sv
// mrsp_checker: port-level assertions for midi_running_status_parser_core,
// attached by the bind below. No package dependency.
`default_nettype none

module mrsp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       msg_valid,
    input wire logic       msg_stall,
    input wire logic [7:0] msg_status,
    input wire logic [6:0] data_first,
    input wire logic [6:0] data_second
);

    // stalled beat stays
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_stall |=> msg_valid)
        else $error("msg_valid dropped under stall");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_stall |=> $stable(msg_status) && $stable(data_first) &&
            $stable(data_second))
        else $error("msg payload changed under stall");

    // only channel messages come out
    a_channel_status: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid |-> msg_status[7] && (msg_status[7:4] != 4'hF))
        else $error("non-channel status emitted");

    // one-data-byte commands carry zero second byte
    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && (msg_status[7:4] == 4'hC || msg_status[7:4] == 4'hD)
            |-> data_second == 7'd0)
        else $error("one-byte message with nonzero second byte");

    // zero-velocity note-on must have become a note-off
    a_note_on_velocity: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_status[7:4] == 4'h9 |-> data_second != 7'd0)
        else $error("note-on with zero velocity emitted");

endmodule

bind midi_running_status_parser_core mrsp_checker u_mrsp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .msg_status  (msg_status),
    .data_first  (data_first),
    .data_second (data_second)
);

`default_nettype wire

>>> tb/sv/tb_midi_running_status_parser_core.sv
// tb_midi_running_status_parser_core: self-checking bench for the MIDI running-status
// parser. Carries its own parse predictor and a scoreboard of expected messages.
// Depends on mrsp_pkg and midi_running_status_parser_core.
`timescale 1ns / 1ps

module tb_midi_running_status_parser_core;

    import mrsp_pkg::*;

    // Channel commands the package does not name
    localparam logic [3:0] CMD_POLY_TOUCH = 4'hA;
    localparam logic [3:0] CMD_CONTROL    = 4'hB;
    localparam logic [3:0] CMD_PITCH_BEND = 4'hE;

    // Realtime bytes and end of sysex
    localparam logic [7:0] RT_CLOCK    = 8'hF8;
    localparam logic [7:0] RT_START    = 8'hFA;
    localparam logic [7:0] RT_CONTINUE = 8'hFB;
    localparam logic [7:0] RT_STOP     = 8'hFC;
    localparam logic [7:0] RT_SENSE    = 8'hFE;
    localparam logic [7:0] RT_RESET    = 8'hFF;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    // Watchdog limit, many times the worst correct run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    logic       clk;
    logic       rst_n;
    logic       rx_valid;
    logic       rx_stall;
    logic [7:0] rx_byte;
    logic       overrun;
    logic       msg_valid;
    logic       msg_stall;
    logic [7:0] msg_status;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;

    // Shadow of the parser state and the channel register
    logic [2:0] shadow_mode;
    logic [7:0] shadow_running;
    logic [6:0] shadow_held;
    logic [4:0] shadow_channel;

    msg_beat_t pending_msgs[$];   // messages the DUT still owes, oldest first
    int        mismatches;
    int        bytes_sent;
    int        src_idle_pct;      // chance in 100 of a gap before each rx beat
    int        sink_stall_pct;    // chance in 100 of msg_stall on any cycle
    int        cycle_count;

    midi_running_status_parser_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .overrun     (overrun),
        .msg_valid   (msg_valid),
        .msg_stall   (msg_stall),
        .msg_status  (msg_status),
        .data_first  (data_first),
        .data_second (data_second),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a message that never shows ends here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic is_realtime_byte(input logic [7:0] b);
        return b == RT_CLOCK || b == RT_START || b == RT_CONTINUE ||
               b == RT_STOP || b == RT_SENSE || b == RT_RESET;
    endfunction

    function automatic void reset_shadow();
        shadow_mode    = MODE_RESET;
        shadow_running = 8'h00;
        shadow_held    = 7'h00;
        shadow_channel = ALL_CHANNELS;
    endfunction

    // Advances the shadow parser by one accepted rx beat. Returns 1 and fills
    // msg when the beat completes a channel message that passes the filter.
    function automatic logic predict_midi_msg(input rx_beat_t beat,
                                              output msg_beat_t msg);
        logic [3:0] cmd;
        logic       chan_ok;
        msg = '0;
        // Overrun throws the byte away and restarts parsing, but running
        // status and the held byte survive.
        if (beat.overrun)
        begin
            shadow_mode = MODE_RESET;
            return 1'b0;
        end
        // Realtime bytes may land anywhere, even mid-sysex, with no effect.
        if (is_realtime_byte(beat.rx_byte))
            return 1'b0;
        if (beat.rx_byte[7])
        begin
            shadow_running = beat.rx_byte;
            cmd = beat.rx_byte[7:4];
            if (beat.rx_byte == SYSEX_START)
                shadow_mode = MODE_SYSEX;
            else if (cmd == CMD_SYSTEM)
                shadow_mode = MODE_RESET;   // system common: data dropped after it
            else if (cmd == CMD_PROGRAM || cmd == CMD_PRESSURE)
                shadow_mode = MODE_SINGLE;
            else
                shadow_mode = MODE_FIRST;
            return 1'b0;
        end
        // Data byte from here on
        if (shadow_mode != MODE_SINGLE && shadow_mode != MODE_FIRST &&
            shadow_mode != MODE_SECOND)
            return 1'b0;
        if (shadow_running[7:4] == CMD_SYSTEM)
            return 1'b0;
        // Filter on the status channel; a rejected byte leaves the parse alone.
        chan_ok = (shadow_channel == ALL_CHANNELS) ||
                  (shadow_running[3:0] == shadow_channel[3:0]);
        if (!chan_ok)
            return 1'b0;
        case (shadow_mode)
            MODE_FIRST:
            begin
                shadow_held = beat.rx_byte[6:0];
                shadow_mode = MODE_SECOND;
                return 1'b0;
            end
            MODE_SECOND:
            begin
                shadow_mode = MODE_FIRST;
                msg.data_first = shadow_held;
                // note-on with zero velocity goes out as note-off
                if (shadow_running[7:4] == CMD_NOTE_ON && beat.rx_byte == 8'h00)
                begin
                    msg.msg_status  = {CMD_NOTE_OFF, shadow_running[3:0]};
                    msg.data_second = 7'h00;
                end
                else
                begin
                    msg.msg_status  = shadow_running;
                    msg.data_second = beat.rx_byte[6:0];
                end
                return 1'b1;
            end
            default:
            begin
                // single-data message: program change or channel pressure
                msg.msg_status  = shadow_running;
                msg.data_first  = beat.rx_byte[6:0];
                msg.data_second = 7'h00;
                return 1'b1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sink side: random stall and result checking
    // ------------------------------------------------------------------

    always @(posedge clk)
        msg_stall <= (sink_stall_pct != 0) && ($urandom_range(0, 99) < sink_stall_pct);

    // Every beat taken on the msg side is checked against the oldest expectation.
    always @(posedge clk)
    begin
        msg_beat_t got;
        msg_beat_t want;
        if (rst_n && msg_valid && !msg_stall)
        begin
            got.msg_status  = msg_status;
            got.data_first  = data_first;
            got.data_second = data_second;
            if (pending_msgs.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected msg beat status=%h d1=%h d2=%h",
                             $realtime, got.msg_status, got.data_first, got.data_second);
                mismatches++;
            end
            else
            begin
                want = pending_msgs.pop_front();
                if (got.msg_status !== want.msg_status ||
                    got.data_first !== want.data_first ||
                    got.data_second !== want.data_second)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: msg mismatch exp %h/%h/%h got %h/%h/%h",
                                 $realtime, want.msg_status, want.data_first,
                                 want.data_second, got.msg_status, got.data_first,
                                 got.data_second);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Drives one rx beat, holds it through any stall, and predicts on accept.
    task automatic send_byte(input logic [7:0] b, input logic ov);
        rx_beat_t  beat;
        msg_beat_t msg;
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        overrun  <= ov;
        do
            @(posedge clk);
        while (rx_stall);
        beat.rx_byte = b;
        beat.overrun = ov;
        if (predict_midi_msg(beat, msg))
            pending_msgs.push_back(msg);
        bytes_sent++;
    endtask

    // Drops rx_valid and waits until every owed message has been taken.
    // The wait loop always runs at least once, so rx_valid is not re-driven in this step.
    task automatic drain_results();
        rx_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_msgs.size() != 0);
    endtask

    // Writes own_channel with the parser idle. A trailing byte that makes no
    // message may still sit in the two-stage pipe, hence the short pause.
    task automatic write_own_channel(input logic [4:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_channel = value;
    endtask

    function automatic logic [7:0] rand_realtime();
        case ($urandom_range(0, 5))
            0:       return RT_CLOCK;
            1:       return RT_START;
            2:       return RT_CONTINUE;
            3:       return RT_STOP;
            4:       return RT_SENSE;
            default: return RT_RESET;
        endcase
    endfunction

    // Channel for a random message: mostly the accepted one when filtering.
    function automatic logic [3:0] pick_channel();
        if (shadow_channel != ALL_CHANNELS && $urandom_range(0, 9) < 7)
            return shadow_channel[3:0];
        return 4'($urandom_range(0, 15));
    endfunction

    // One random group: mostly well-formed channel traffic (with and without
    // a fresh status), some sysex, system common, overruns and raw noise.
    task automatic send_random_group();
        int         kind;
        int         n;
        logic [3:0] cmd;
        logic [7:0] d;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            cmd = CMD_NOTE_OFF + 4'($urandom_range(0, 6));
            if ($urandom_range(0, 3) != 0)
                send_byte({cmd, pick_channel()}, 1'b0);
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_byte(rand_realtime(), 1'b0);
                if ($urandom_range(0, 6) == 0)
                    d = 8'h00;   // zero velocity for note-on turns it into note-off
                else
                    d = 8'($urandom_range(0, 127));
                send_byte(d, 1'b0);
            end
        end
        else if (kind < 78)
        begin
            send_byte(SYSEX_START, 1'b0);
            n = $urandom_range(0, 5);
            repeat (n)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_byte(rand_realtime(), 1'b0);
                send_byte(8'($urandom_range(0, 127)), 1'b0);
            end
            send_byte(SYSEX_END, 1'b0);
        end
        else if (kind < 84)
        begin
            send_byte(SYSEX_START + 8'($urandom_range(1, 7)), 1'b0);
            n = $urandom_range(0, 3);
            repeat (n)
                send_byte(8'($urandom_range(0, 127)), 1'b0);
        end
        else if (kind < 90)
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        else
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 9) == 0));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every channel command, data extremes, running status, zero-velocity
    // note-on, a realtime byte inside a message, and a data byte before any status.
    task automatic test_message_types();
        write_own_channel(ALL_CHANNELS);
        send_byte(8'h45, 1'b0);                   // data with no status yet: dropped
        send_byte({CMD_NOTE_ON, 4'h0}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h3C, 1'b0);                   // running status
        send_byte(8'h00, 1'b0);                   // velocity 0 -> note-off
        send_byte({CMD_PROGRAM, 4'hF}, 1'b0);
        send_byte(RT_CLOCK, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);                   // second program change by running status
        send_byte({CMD_PRESSURE, 4'h3}, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte({CMD_PITCH_BEND, 4'h7}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(RT_RESET, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte({CMD_NOTE_OFF, 4'hA}, 1'b0);
        send_byte(8'h2A, 1'b0);
        send_byte(8'h00, 1'b0);                   // note-off velocity 0 stays note-off
        send_byte({CMD_POLY_TOUCH, 4'h1}, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte({CMD_CONTROL, 4'hC}, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h64, 1'b0);
    endtask

    // Sysex with embedded realtime, data after a system common byte, and an
    // overrun in the middle of a message.
    task automatic test_system_and_overrun();
        send_byte(SYSEX_START, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(RT_SENSE, 1'b0);
        send_byte(SYSEX_END, 1'b0);
        send_byte(8'h12, 1'b0);                   // after F7 parse is in reset: dropped
        send_byte({CMD_NOTE_ON, 4'h2}, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'hAA, 1'b1);                   // overrun: parse restarts
        send_byte(8'h41, 1'b0);                   // dropped
        send_byte({CMD_NOTE_ON, 4'h2}, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
    endtask

    // Filter on a single channel, both ends of the channel range.
    task automatic test_channel_filter();
        write_own_channel(5'd0);
        send_byte({CMD_NOTE_ON, 4'h5}, 1'b0);
        send_byte(8'h10, 1'b0);                   // wrong channel: dropped
        send_byte(8'h20, 1'b0);
        send_byte({CMD_NOTE_ON, 4'h0}, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        write_own_channel(5'd15);
        send_byte({CMD_NOTE_OFF, 4'hF}, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte({CMD_PROGRAM, 4'hE}, 1'b0);
        send_byte(8'h03, 1'b0);                   // wrong channel: dropped
    endtask

    // Random traffic under one channel setting and one idle profile.
    task automatic test_random_traffic(input logic [4:0] channel, input int src_pct,
                                       input int sink_pct, input int n_bytes);
        int stop_at;
        write_own_channel(channel);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            send_random_group();
    endtask

    // Sender holds off until the sink has taken every owed message, then resumes.
    task automatic test_drain_pause();
        src_idle_pct   = 0;
        sink_stall_pct = 50;
        repeat (3)
        begin
            repeat ($urandom_range(3, 8))
                send_random_group();
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        rx_valid       = 1'b0;
        rx_byte        = 8'h00;
        overrun        = 1'b0;
        msg_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 5'd0;
        mismatches     = 0;
        bytes_sent     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        reset_shadow();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_message_types();
        test_system_and_overrun();
        test_channel_filter();

        // sender sparse gaps with heavy sink stall, then the reverse, then full rate around a drain pause
        test_random_traffic(ALL_CHANNELS, 10, 85, 500);
        test_random_traffic(5'($urandom_range(1, 14)), 85, 10, 500);
        test_random_traffic(5'd15, 0, 0, 250);
        test_drain_pause();
        test_random_traffic(5'd0, 0, 0, 250);

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_msgs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
